/* design/pet_pkg.sv */
// Shared types, codes and constants of the priority eviction table.
package pet_pkg;

  localparam int SLOT_W        = 4;
  localparam int BUD_W         = 16;
  localparam int PRI_W         = 8;
  localparam int TOT_W         = 20;
  localparam int NUM_SLOTS_DEF = 16;

  localparam logic signed [PRI_W-1:0] NEP_RESET = 8'sd100;

  typedef logic signed [PRI_W-1:0] prio_t;

  typedef enum logic [2:0] {
    OP_REGISTER     = 3'd0,
    OP_LOADED       = 3'd1,
    OP_UNLOADED     = 3'd2,
    OP_SET_IDLE     = 3'd3,
    OP_SET_PRIORITY = 3'd4,
    OP_TOTAL        = 3'd5,
    OP_CANDIDATES   = 3'd6,
    OP_BUDGET       = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOT_REG = 2'd1,
    ST_ALREADY = 2'd2
  } status_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [SLOT_W-1:0]   slot;
    logic [BUD_W-1:0]    budget_req;
    logic signed [PRI_W-1:0] priority_req;
    logic                idle_flag;
    logic [TOT_W-1:0]    target_req;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [TOT_W-1:0]    total_mib;
    logic                below_target;
    logic [SLOT_W-1:0]   entry_slot;
    logic [BUD_W-1:0]    entry_budget;
    logic signed [PRI_W-1:0] entry_priority;
    logic                candidate_valid;
    logic                last;
  } out_item_t;

  typedef enum logic [2:0] {
    RES_SIMPLE,
    RES_BUDGET,
    RES_TOTAL,
    RES_CAND,
    RES_EMPTY
  } res_sel_e;

  typedef enum logic [1:0] {
    SCAN_TOTAL,
    SCAN_MASK,
    SCAN_SELECT
  } scan_mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WRITE,
    S_BUDGET,
    S_SCAN,
    S_DRAIN,
    S_CHECK,
    S_TOTAL_OUT,
    S_EMIT,
    S_EMPTY
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       capture;
    logic       commit;
    logic       rd_slot;
    logic       scan_start;
    logic       scan_issue;
    scan_mode_e scan_mode;
    logic       load_out;
    res_sel_e   res_sel;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    opcode_e opcode;
    logic    scan_last;
    logic    mask_empty;
    logic    cand_last;
    logic    out_free;
  } sts_t;

endpackage

/* design/pet_chan_if.sv */
// Valid/ready channel carrying one item of payload type T.
interface pet_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* design/pet_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/pet_dp.sv */
// Datapath: slot flags, budget/priority RAMs, scan pipeline and result register.
module pet_dp #(
  parameter int NUM_SLOTS = pet_pkg::NUM_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pet_pkg::cmd_t      cmd_i,
  output pet_pkg::sts_t      sts_o,
  input  pet_pkg::in_item_t  in_item_i,
  input  logic               cfg_we_i,
  input  pet_pkg::prio_t     cfg_nep_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pet_pkg::out_item_t out_item_o
);

  localparam int IDX_W = $clog2(NUM_SLOTS);

  pet_pkg::in_item_t  req_q;
  pet_pkg::prio_t     nep_q;
  pet_pkg::out_item_t out_q, res;
  logic               out_vld_q;

  logic [NUM_SLOTS-1:0] valid_q, loaded_q, idle_q, cand_q;

  logic [IDX_W-1:0] slot_idx, scan_idx_q, rd_idx_q, best_idx_q, raddr;
  logic             rd_vld_q, best_vld_q;
  logic [pet_pkg::BUD_W-1:0] bud_rd, best_bud_q;
  logic [pet_pkg::PRI_W-1:0] pri_rd;
  pet_pkg::prio_t   pri_rd_s, best_pri_q;
  logic [pet_pkg::TOT_W-1:0] acc_q;

  logic in_range, is_reg, out_free, wins, cand_last, bud_we, pri_we;

  assign slot_idx = IDX_W'(req_q.slot);
  assign in_range = 32'(req_q.slot) < 32'(NUM_SLOTS);
  assign is_reg   = in_range && valid_q[slot_idx];
  assign out_free = !out_vld_q || out_ready_i;
  assign pri_rd_s = $signed(pri_rd);
  assign raddr    = cmd_i.scan_issue ? scan_idx_q : slot_idx;

  // RAM writes at commit
  assign bud_we = cmd_i.commit && req_q.opcode == pet_pkg::OP_REGISTER && in_range
                  && !valid_q[slot_idx];
  assign pri_we = bud_we
                  || (cmd_i.commit && req_q.opcode == pet_pkg::OP_SET_PRIORITY && is_reg);

  pet_ram #(.WIDTH(pet_pkg::BUD_W), .DEPTH(NUM_SLOTS)) u_bud_ram (
    .clk_i   (clk_i),
    .we_i    (bud_we),
    .waddr_i (slot_idx),
    .wdata_i (req_q.budget_req),
    .re_i    (cmd_i.scan_issue || cmd_i.rd_slot),
    .raddr_i (raddr),
    .rdata_o (bud_rd)
  );

  pet_ram #(.WIDTH(pet_pkg::PRI_W), .DEPTH(NUM_SLOTS)) u_pri_ram (
    .clk_i   (clk_i),
    .we_i    (pri_we),
    .waddr_i (slot_idx),
    .wdata_i (req_q.priority_req),
    .re_i    (cmd_i.scan_issue || cmd_i.rd_slot),
    .raddr_i (raddr),
    .rdata_o (pri_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nep_q <= pet_pkg::NEP_RESET;
    end else if (cfg_we_i) begin
      nep_q <= cfg_nep_i;
    end
  end

  // slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      loaded_q <= '0;
      idle_q   <= '1;
    end else if (cmd_i.commit) begin
      unique case (req_q.opcode)
        pet_pkg::OP_REGISTER: begin
          if (in_range && !valid_q[slot_idx]) begin
            valid_q[slot_idx]  <= 1'b1;
            loaded_q[slot_idx] <= 1'b0;
            idle_q[slot_idx]   <= 1'b1;
          end
        end
        pet_pkg::OP_LOADED: begin
          if (is_reg) loaded_q[slot_idx] <= 1'b1;
        end
        pet_pkg::OP_UNLOADED: begin
          if (is_reg) begin
            loaded_q[slot_idx] <= 1'b0;
            idle_q[slot_idx]   <= 1'b1;
          end
        end
        pet_pkg::OP_SET_IDLE: begin
          if (is_reg) idle_q[slot_idx] <= req_q.idle_flag;
        end
        default: begin
        end
      endcase
    end
  end

  // scan address counter and registered read pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_issue;
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
      end else if (cmd_i.scan_issue) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_idx_q;
  end

  // strictly earlier in eviction order; equal keys keep the lower slot
  assign wins = !best_vld_q || (pri_rd_s < best_pri_q)
                || (pri_rd_s == best_pri_q && bud_rd > best_bud_q);

  assign cand_last = (cand_q & ~(NUM_SLOTS'(1) << best_idx_q)) == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q     <= '0;
      best_vld_q <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        best_vld_q <= 1'b0;
      end else if (rd_vld_q && cmd_i.scan_mode == pet_pkg::SCAN_SELECT
                   && cand_q[rd_idx_q] && wins) begin
        best_vld_q <= 1'b1;
      end
      if (rd_vld_q && cmd_i.scan_mode == pet_pkg::SCAN_MASK) begin
        cand_q[rd_idx_q] <= valid_q[rd_idx_q] && loaded_q[rd_idx_q]
                            && idle_q[rd_idx_q] && (pri_rd_s < nep_q);
      end else if (cmd_i.load_out && cmd_i.res_sel == pet_pkg::RES_CAND) begin
        cand_q[best_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      acc_q <= '0;
    end else if (rd_vld_q && cmd_i.scan_mode == pet_pkg::SCAN_TOTAL
                 && valid_q[rd_idx_q] && loaded_q[rd_idx_q]) begin
      acc_q <= acc_q + pet_pkg::TOT_W'(bud_rd);
    end
    if (rd_vld_q && cmd_i.scan_mode == pet_pkg::SCAN_SELECT && cand_q[rd_idx_q] && wins) begin
      best_idx_q <= rd_idx_q;
      best_bud_q <= bud_rd;
      best_pri_q <= pri_rd_s;
    end
  end

  always_comb begin
    res        = '0;
    res.status = pet_pkg::ST_OK;
    res.last   = 1'b1;
    unique case (cmd_i.res_sel)
      pet_pkg::RES_SIMPLE: begin
        priority if (!in_range) begin
          res.status = pet_pkg::ST_NOT_REG;
        end else if (req_q.opcode == pet_pkg::OP_REGISTER) begin
          if (valid_q[slot_idx]) res.status = pet_pkg::ST_ALREADY;
        end else if (!valid_q[slot_idx]) begin
          res.status = pet_pkg::ST_NOT_REG;
        end
      end
      pet_pkg::RES_BUDGET: begin
        res.status       = is_reg ? pet_pkg::ST_OK : pet_pkg::ST_NOT_REG;
        res.entry_budget = is_reg ? bud_rd : '0;
      end
      pet_pkg::RES_TOTAL: begin
        res.total_mib    = acc_q;
        res.below_target = acc_q < req_q.target_req;
      end
      pet_pkg::RES_CAND: begin
        res.entry_slot      = pet_pkg::SLOT_W'(best_idx_q);
        res.entry_budget    = best_bud_q;
        res.entry_priority  = best_pri_q;
        res.candidate_valid = 1'b1;
        res.last            = cand_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  assign sts_o.opcode     = req_q.opcode;
  assign sts_o.scan_last  = scan_idx_q == IDX_W'(NUM_SLOTS - 1);
  assign sts_o.mask_empty = cand_q == '0;
  assign sts_o.cand_last  = cand_last;
  assign sts_o.out_free   = out_free;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> out_free)
    else $error("result register overwritten while still pending");

  a_cand_registered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cand_q & ~valid_q) == '0)
    else $error("candidate mask holds an unregistered slot");

  a_emit_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && cmd_i.res_sel == pet_pkg::RES_CAND) |-> (best_vld_q && cand_q[best_idx_q]))
    else $error("candidate emitted without a selected pending slot");

endmodule

/* design/pet_ctrl.sv */
// Controller: sequences decode, table updates, slot scans and result hand-off.
module pet_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output pet_pkg::cmd_t cmd_o,
  input  pet_pkg::sts_t sts_i
);

  pet_pkg::state_e     state_q, state_d;
  pet_pkg::scan_mode_e mode_q, mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pet_pkg::S_IDLE;
      mode_q  <= pet_pkg::SCAN_TOTAL;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    mode_d           = mode_q;
    cmd_o            = '0;
    cmd_o.scan_mode  = mode_q;
    cmd_o.res_sel    = pet_pkg::RES_SIMPLE;
    in_ready_o       = state_q == pet_pkg::S_IDLE;
    unique case (state_q)
      pet_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = pet_pkg::S_DECODE;
        end
      end
      pet_pkg::S_DECODE: begin
        unique case (sts_i.opcode)
          pet_pkg::OP_TOTAL: begin
            cmd_o.scan_start = 1'b1;
            mode_d           = pet_pkg::SCAN_TOTAL;
            state_d          = pet_pkg::S_SCAN;
          end
          pet_pkg::OP_CANDIDATES: begin
            cmd_o.scan_start = 1'b1;
            mode_d           = pet_pkg::SCAN_MASK;
            state_d          = pet_pkg::S_SCAN;
          end
          pet_pkg::OP_BUDGET: begin
            cmd_o.rd_slot = 1'b1;
            state_d       = pet_pkg::S_BUDGET;
          end
          default: begin
            state_d = pet_pkg::S_WRITE;
          end
        endcase
      end
      pet_pkg::S_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.commit   = 1'b1;
          cmd_o.load_out = 1'b1;
          state_d        = pet_pkg::S_IDLE;
        end
      end
      pet_pkg::S_BUDGET: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.res_sel  = pet_pkg::RES_BUDGET;
          state_d        = pet_pkg::S_IDLE;
        end
      end
      pet_pkg::S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) state_d = pet_pkg::S_DRAIN;
      end
      pet_pkg::S_DRAIN: begin
        unique case (mode_q)
          pet_pkg::SCAN_TOTAL: state_d = pet_pkg::S_TOTAL_OUT;
          pet_pkg::SCAN_MASK:  state_d = pet_pkg::S_CHECK;
          default:             state_d = pet_pkg::S_EMIT;
        endcase
      end
      pet_pkg::S_CHECK: begin
        if (sts_i.mask_empty) begin
          state_d = pet_pkg::S_EMPTY;
        end else begin
          cmd_o.scan_start = 1'b1;
          mode_d           = pet_pkg::SCAN_SELECT;
          state_d          = pet_pkg::S_SCAN;
        end
      end
      pet_pkg::S_TOTAL_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.res_sel  = pet_pkg::RES_TOTAL;
          state_d        = pet_pkg::S_IDLE;
        end
      end
      pet_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.res_sel  = pet_pkg::RES_CAND;
          if (sts_i.cand_last) begin
            state_d = pet_pkg::S_IDLE;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = pet_pkg::S_SCAN;
          end
        end
      end
      pet_pkg::S_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.res_sel  = pet_pkg::RES_EMPTY;
          state_d        = pet_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pet_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* design/priority_eviction_table_top.sv */
// Top level of the priority eviction table: channels, controller and datapath.
//
// A table of NUM_SLOTS client slots (valid, loaded, idle, budget, priority) driven by one
// opcode per input item. Only slots 0..15 are addressable by the 4-bit slot field. One item
// is worked on at a time; input ready is high while the controller is idle, and a finished
// result sits in an output register so the next item can be taken while it waits. Total
// makes one pass over all slots, one slot read per cycle from the budget RAM, then a pipeline
// drain; candidates makes one mask pass, then one full slot scan per listed candidate
// (selection of the next-lowest key over the budget/priority RAM read port), and emits an
// empty result when there are none. Every result waits in the output register for as long
// as the receiver holds ready low. Budget and priority live in RAMs with no reset; their
// content is only used for registered slots. never_evict_priority resets to 100 and may be
// written any time the block is idle; the config channel is always ready.
module priority_eviction_table_top #(
  parameter int NUM_SLOTS = pet_pkg::NUM_SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pet_chan_if.sink         in_i,
  pet_chan_if.source       out_o,
  pet_chan_if.sink         cfg_i
);

  pet_pkg::cmd_t cmd;
  pet_pkg::sts_t sts;

  // config register write: always accepted
  assign cfg_i.ready = 1'b1;

  pet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  pet_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_i.payload),
    .cfg_we_i    (cfg_i.valid),
    .cfg_nep_i   (cfg_i.payload),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_o.payload)
  );

endmodule
